// File: sv/bmm_pkg.sv
package bmm_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned DWordW = 128;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned CfgIdxW = 2;

  // Number of register stages from input transfer to output register
  localparam int unsigned NumStg = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_FACTOR  = 2'd1,
    CFG_SHIFT   = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  localparam logic [ShiftW-1:0] ShiftRst = 7'd64;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [DWordW-1:0] dword_t;

endpackage

// File: sv/barrett_modular_multiply.sv
// Barrett modular multiplier: product_mod = (operand_a * operand_b) reduced by the
// configured modulus using the configured Barrett factor and total shift (0..127).
// Fully pipelined: one operand pair can be transferred every cycle unless the master
// side stalls the output. A result reaches the output register after its input
// transfer through nine register stages. The depth comes from
// three multiplication rounds (a*b, both halves times the factor, quotient times
// modulus), each split into 32x32 partial products with a stage to form the products,
// plus the quotient shift and the two correction subtractions. Stages only advance
// into free slots, so bubbles collapse and the input stays ready while a result waits
// as long as any stage is empty; with all nine stages full and held the input stalls.
// Configuration must only be written while no item is in flight; a zero modulus gives
// a zero result.
module barrett_modular_multiply
  import bmm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [WordW-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*WordW-1:0]   s_axis_tdata_i,  // [63:0] operand_a, [127:64] operand_b
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [WordW-1:0]     m_axis_tdata_o   // [63:0] product_mod
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  word_t             modulus_q;
  word_t             factor_q;
  logic [ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '0;
      factor_q  <= '0;
      shift_q   <= ShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS: modulus_q <= cfg_data_i;
        CFG_FACTOR:  factor_q  <= cfg_data_i;
        CFG_SHIFT:   shift_q   <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when its contents move on
  // ---------------------------------------------------------------------------
  logic [NumStg:1] vld_q;
  logic [NumStg:1] ld;

  always_comb begin
    ld[NumStg] = !vld_q[NumStg] || m_axis_tready_i;
    for (int k = NumStg - 1; k >= 1; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NumStg; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = ld[1];
  assign m_axis_tvalid_o = vld_q[NumStg];

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  word_t opa, opb;
  assign opa = s_axis_tdata_i[WordW-1:0];
  assign opb = s_axis_tdata_i[2*WordW-1:WordW];

  // stage 1: partial products of a*b
  word_t ab00_q, ab01_q, ab10_q, ab11_q;
  // stage 2: full product
  dword_t prod_q;
  // stage 3: partial products of hi*factor and lo*factor
  word_t hf00_q, hf01_q, hf10_q, hf11_q;
  word_t lf00_q, lf01_q, lf10_q, lf11_q;
  word_t lo3_q;
  // stage 4: wide partial products
  dword_t ph_q, pl_q;
  word_t  lo4_q;
  // stage 5: low word of the quotient estimate
  word_t q_q, lo5_q;
  // stage 6: partial products of q*modulus (low word only)
  word_t qm00_q, qm01_q, qm10_q, lo6_q;
  // stages 7..9: remainder and corrections
  word_t r0_q, r1_q, r2_q;

  word_t  prod_hi, prod_lo;
  logic [3*WordW-1:0] ph_sh;
  dword_t pl_sh;
  word_t  qm_lo;
  word_t  r0_d, r1_d, r2_d, q_d;
  dword_t prod_d, ph_d, pl_d;

  assign prod_hi = prod_q[DWordW-1:WordW];
  assign prod_lo = prod_q[WordW-1:0];

  // combine four 32x32 products into a 128-bit product
  function automatic dword_t comb4(word_t p00, word_t p01, word_t p10, word_t p11);
    dword_t mid;
    mid = dword_t'(p01) + dword_t'(p10);
    return dword_t'(p00) + (mid << HalfW) + (dword_t'(p11) << WordW);
  endfunction

  assign prod_d = comb4(ab00_q, ab01_q, ab10_q, ab11_q);
  assign ph_d   = comb4(hf00_q, hf01_q, hf10_q, hf11_q);
  assign pl_d   = comb4(lf00_q, lf01_q, lf10_q, lf11_q);

  // {ph, 0} >> s covers both ph >> (s-64) and ph << (64-s) in its low word
  assign ph_sh = {ph_q, {WordW{1'b0}}} >> shift_q;
  assign pl_sh = pl_q >> shift_q;
  assign q_d   = ph_sh[WordW-1:0] + pl_sh[WordW-1:0];

  assign qm_lo = qm00_q + ((qm01_q + qm10_q) << HalfW);
  assign r0_d  = lo6_q - qm_lo;
  assign r1_d  = (r0_q >= modulus_q) ? r0_q - modulus_q : r0_q;
  assign r2_d  = (modulus_q == '0) ? '0 :
                 ((r1_q >= modulus_q) ? r1_q - modulus_q : r1_q);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      ab00_q <= word_t'(opa[HalfW-1:0])     * word_t'(opb[HalfW-1:0]);
      ab01_q <= word_t'(opa[HalfW-1:0])     * word_t'(opb[WordW-1:HalfW]);
      ab10_q <= word_t'(opa[WordW-1:HalfW]) * word_t'(opb[HalfW-1:0]);
      ab11_q <= word_t'(opa[WordW-1:HalfW]) * word_t'(opb[WordW-1:HalfW]);
    end
    if (ld[2]) begin
      prod_q <= prod_d;
    end
    if (ld[3]) begin
      hf00_q <= word_t'(prod_hi[HalfW-1:0])     * word_t'(factor_q[HalfW-1:0]);
      hf01_q <= word_t'(prod_hi[HalfW-1:0])     * word_t'(factor_q[WordW-1:HalfW]);
      hf10_q <= word_t'(prod_hi[WordW-1:HalfW]) * word_t'(factor_q[HalfW-1:0]);
      hf11_q <= word_t'(prod_hi[WordW-1:HalfW]) * word_t'(factor_q[WordW-1:HalfW]);
      lf00_q <= word_t'(prod_lo[HalfW-1:0])     * word_t'(factor_q[HalfW-1:0]);
      lf01_q <= word_t'(prod_lo[HalfW-1:0])     * word_t'(factor_q[WordW-1:HalfW]);
      lf10_q <= word_t'(prod_lo[WordW-1:HalfW]) * word_t'(factor_q[HalfW-1:0]);
      lf11_q <= word_t'(prod_lo[WordW-1:HalfW]) * word_t'(factor_q[WordW-1:HalfW]);
      lo3_q  <= prod_lo;
    end
    if (ld[4]) begin
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      lo4_q <= lo3_q;
    end
    if (ld[5]) begin
      q_q   <= q_d;
      lo5_q <= lo4_q;
    end
    if (ld[6]) begin
      qm00_q <= word_t'(q_q[HalfW-1:0])     * word_t'(modulus_q[HalfW-1:0]);
      qm01_q <= word_t'(q_q[HalfW-1:0])     * word_t'(modulus_q[WordW-1:HalfW]);
      qm10_q <= word_t'(q_q[WordW-1:HalfW]) * word_t'(modulus_q[HalfW-1:0]);
      lo6_q  <= lo5_q;
    end
    if (ld[7]) begin
      r0_q <= r0_d;
    end
    if (ld[8]) begin
      r1_q <= r1_d;
    end
    if (ld[9]) begin
      r2_q <= r2_d;
    end
  end

  assign m_axis_tdata_o = r2_q;

`ifndef ASSERT_OFF
  // an empty output slot lets every stage advance
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStg] |-> s_axis_tready_o)
    else $error("input not ready with empty output stage");

  // an input transfer always lands in the first stage
  a_transfer_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[1])
    else $error("input transfer lost at first stage");

  // a blocked item in the first correction stage keeps its value
  a_stage8_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] && !ld[8] |=> vld_q[8] && $stable(r1_q))
    else $error("stalled stage 8 item changed or dropped");
`endif

endmodule
